>>> hw/rtl/bs_pkg.sv
// Bitonic sorter shared package: field widths, register map and reset values.
// No dependencies; every other file refers to it by scoped names.
package bs_pkg;

  localparam int DATA_W  = 32;   // width of one sample word
  localparam int CNT_W   = 7;    // width of the element_count register
  localparam int LVL_W   = 3;    // width of the stage and step counters
  localparam int PADDR_W = 3;    // configuration byte address width
  localparam int PDATA_W = 32;   // configuration data width

  // Register map, word index taken from paddr[2]
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

  typedef logic signed [DATA_W-1:0] word_t;

endpackage

>>> hw/rtl/bs_store.sv
// Value store of the bitonic sorter: one write port, two registered read ports.
// Depends on bs_pkg for the word type.
module bs_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  bs_pkg::word_t    wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output bs_pkg::word_t    rdata_a,
  output bs_pkg::word_t    rdata_b
);

  bs_pkg::word_t mem [DEPTH];
  bs_pkg::word_t rdata_a_r;
  bs_pkg::word_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> hw/rtl/bs_mate.sv
// Partner index generator of the bitonic network for one scan position.
// Depends on bs_pkg for the stage and step counter widths.
module bs_mate #(
  parameter int CW = 7
) (
  input  logic [CW-1:0]            elem,
  input  logic [bs_pkg::LVL_W-1:0] stage,
  input  logic [bs_pkg::LVL_W-1:0] step,
  input  logic [CW-1:0]            count,
  output logic [CW-1:0]            mate,
  output logic                     pair_ok
);

  logic [bs_pkg::LVL_W-1:0] span;
  logic [CW:0]              box;
  logic [CW-1:0]            flip;

  always_comb begin
    span = stage - step + bs_pkg::LVL_W'(1);
    box  = (CW+1)'(1) << span;
    // first step of a stage mirrors inside the box, later steps jump half a box
    if (step == bs_pkg::LVL_W'(1)) begin
      flip = CW'(box - (CW+1)'(1));
    end else begin
      flip = CW'(box >> 1);
    end
    mate    = elem ^ flip;
    pair_ok = (mate > elem) && (mate < count);
  end

endmodule

>>> hw/rtl/bitonic_sorter.sv
// Bitonic sorter top level: load sequencer, network sequencer and output stage.
// Depends on bs_pkg, bs_store and bs_mate.
//
//   channel   ports            direction  word contents
//   input     in_tvalid/tready  in        tdata[31:0] sample_value (signed)
//   result    out_tvalid/tready out       tdata[31:0] sorted_value, tlast last_value
//   config    cfg_psel/penable  in        element_count at byte address 0
//
// Each loaded word goes into the store; the word that completes a set starts the
// network (a single-value set goes straight to readout), which visits every scan
// position of every step, adding a compare state per valid pair and a second write
// state per swap, all through the single store write port and one comparator. Each
// sorted word is then read out of the store through a read state and a load state.
// Reset clears the sequencer, counters and output valid; the store holds garbage
// until loaded. A stalled result holds in the output register; the next set's
// first word is taken while the last result of the previous set still waits.
module bitonic_sorter #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic signed [31:0]          in_tdata,   // [31:0] sample_value
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic signed [31:0]          out_tdata,  // [31:0] sorted_value
  output logic                        out_tlast,  // last_value
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bs_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [bs_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [bs_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_LOAD  = 3'd0;  // take sample words
  localparam logic [2:0] S_CHECK = 3'd1;  // scan position, reads issued
  localparam logic [2:0] S_CMP   = 3'd2;  // compare, write lower entry
  localparam logic [2:0] S_WR2   = 3'd3;  // write upper entry of a swap
  localparam logic [2:0] S_EMRD  = 3'd4;  // read next sorted word
  localparam logic [2:0] S_EMLD  = 3'd5;  // load output register

  logic [2:0]               state_r, state_nxt;
  logic [bs_pkg::CNT_W-1:0] count_r;
  logic [CW-1:0]            load_r, load_nxt;
  logic [bs_pkg::LVL_W-1:0] stage_r, stage_nxt;
  logic [bs_pkg::LVL_W-1:0] step_r, step_nxt;
  logic [CW-1:0]            elem_r, elem_nxt;
  logic [CW-1:0]            emit_r, emit_nxt;
  bs_pkg::word_t            hold_r, hold_nxt;
  logic                     out_valid_r, out_valid_nxt;
  bs_pkg::word_t            out_data_r, out_data_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [CW-1:0]            n_eff;
  logic [bs_pkg::LVL_W-1:0] levels;
  logic [CW-1:0]            mate;
  logic                     pair_ok;
  logic                     cfg_wr;
  logic                     in_fire;
  logic                     out_fire;
  logic                     last_elem;

  logic                     st_we;
  logic [AW-1:0]            st_waddr;
  bs_pkg::word_t            st_wdata;
  logic [AW-1:0]            st_raddr_a;
  logic [AW-1:0]            st_raddr_b;
  bs_pkg::word_t            st_rdata_a;
  bs_pkg::word_t            st_rdata_b;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == bs_pkg::REG_ELEMENT_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == bs_pkg::REG_ELEMENT_COUNT) ?
                      bs_pkg::PDATA_W'(count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= bs_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      count_r <= cfg_pwdata[bs_pkg::CNT_W-1:0];
    end
  end

  // Clamp the count: zero acts as one, anything above the store depth saturates.
  always_comb begin
    if (count_r == '0) begin
      n_eff = CW'(1);
    end else if (count_r > bs_pkg::CNT_W'(DEPTH)) begin
      n_eff = CW'(DEPTH);
    end else begin
      n_eff = CW'(count_r);
    end
  end

  // Network depth: log2 of the smallest power of two at or above the count.
  always_comb begin
    levels = '0;
    for (int k = 0; k < CW; k++) begin
      if (((CW+1)'(1) << k) < {1'b0, n_eff}) begin
        levels = bs_pkg::LVL_W'(k + 1);
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  bs_mate #(.CW(CW)) u_mate (
    .elem    (elem_r),
    .stage   (stage_r),
    .step    (step_r),
    .count   (n_eff),
    .mate    (mate),
    .pair_ok (pair_ok)
  );

  bs_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (st_raddr_a),
    .raddr_b (st_raddr_b),
    .rdata_a (st_rdata_a),
    .rdata_b (st_rdata_b)
  );

  assign in_tready = (state_r == S_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign last_elem = ((elem_r + CW'(1)) == n_eff);

  // emit states read at the output position, the network at the scan pair
  assign st_raddr_a = ((state_r == S_EMRD) || (state_r == S_EMLD)) ?
                      emit_r[AW-1:0] : elem_r[AW-1:0];
  assign st_raddr_b = mate[AW-1:0];

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    load_nxt      = load_r;
    stage_nxt     = stage_r;
    step_nxt      = step_r;
    elem_nxt      = elem_r;
    emit_nxt      = emit_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    st_we         = 1'b0;
    st_waddr      = elem_r[AW-1:0];
    st_wdata      = st_rdata_b;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          st_we    = 1'b1;
          st_waddr = load_r[AW-1:0];
          st_wdata = in_tdata;
          if ((load_r + CW'(1)) == n_eff) begin
            load_nxt  = '0;
            elem_nxt  = '0;
            emit_nxt  = '0;
            stage_nxt = bs_pkg::LVL_W'(1);
            step_nxt  = bs_pkg::LVL_W'(1);
            // a single value needs no network
            state_nxt = (levels == '0) ? S_EMRD : S_CHECK;
          end else begin
            load_nxt = load_r + CW'(1);
          end
        end
      end
      S_CHECK, S_CMP, S_WR2: begin
        if (state_r == S_CMP && $signed(st_rdata_a) > $signed(st_rdata_b)) begin
          // lower index holds the greater value: swap, lower entry written here, upper in S_WR2
          st_we     = 1'b1;
          st_waddr  = elem_r[AW-1:0];
          st_wdata  = st_rdata_b;
          hold_nxt  = st_rdata_a;
          state_nxt = S_WR2;
        end else if (state_r == S_CHECK && pair_ok) begin
          state_nxt = S_CMP;
        end else begin
          if (state_r == S_WR2) begin
            st_we    = 1'b1;
            st_waddr = mate[AW-1:0];
            st_wdata = hold_r;
          end
          // advance the scan position, step and stage
          state_nxt = S_CHECK;
          if (!last_elem) begin
            elem_nxt = elem_r + CW'(1);
          end else begin
            elem_nxt = '0;
            if (step_r != stage_r) begin
              step_nxt = step_r + bs_pkg::LVL_W'(1);
            end else if (stage_r != levels) begin
              stage_nxt = stage_r + bs_pkg::LVL_W'(1);
              step_nxt  = bs_pkg::LVL_W'(1);
            end else begin
              stage_nxt = '0;
              step_nxt  = '0;
              state_nxt = S_EMRD;
            end
          end
        end
      end
      S_EMRD: begin
        // hold the read until the output register frees up
        if (!out_valid_r || out_tready) begin
          state_nxt = S_EMLD;
        end
      end
      S_EMLD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = st_rdata_a;
        out_last_nxt  = ((emit_r + CW'(1)) == n_eff);
        if ((emit_r + CW'(1)) == n_eff) begin
          emit_nxt  = '0;
          state_nxt = S_LOAD;
        end else begin
          emit_nxt  = emit_r + CW'(1);
          state_nxt = S_EMRD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
    // a count write drops the partial set
    if (cfg_wr) begin
      load_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_r      <= '0;
      stage_r     <= '0;
      step_r      <= '0;
      elem_r      <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_r      <= load_nxt;
      stage_r     <= stage_nxt;
      step_r      <= step_nxt;
      elem_r      <= elem_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------- checks
  a_swap_follows_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR2) |-> $past(state_r == S_CMP))
    else $error("upper swap write without a compare before it");

  a_compare_pair_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (pair_ok && (elem_r < n_eff)))
    else $error("compare on a pair outside the set");

  a_emit_into_free_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMLD) |-> !out_valid_r)
    else $error("sorted word loaded over a pending result");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for bitonic_sorter: streams data sets of signed words,
// predicts the sorted output with its own network model, and checks every result.
// Depends on bs_pkg and the bitonic_sorter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = 64;
  localparam int SETTLE_CYCLES = 16;      // quiet time before a register write
  localparam int END_CYCLES    = 3000;    // covers a full 64-word sort
  localparam int CYCLE_LIMIT   = 800000;
  localparam int REPORT_MAX    = 10;

  localparam logic [bs_pkg::PADDR_W-1:0] COUNT_ADDR = {bs_pkg::REG_ELEMENT_COUNT, 2'b00};

  typedef struct {
    bs_pkg::word_t value;
    logic          last;
  } sorted_word_t;

  // Clock and DUT ports; every input starts at a known value
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  bs_pkg::word_t              in_tdata = '0;      // [31:0] sample_value
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  bs_pkg::word_t              out_tdata;          // [31:0] sorted_value
  logic                       out_tlast;          // last_value
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [bs_pkg::PADDR_W-1:0] cfg_paddr = '0;
  logic [bs_pkg::PDATA_W-1:0] cfg_pwdata = '0;
  logic [bs_pkg::PDATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;

  // Predictor state: configured count, the set being loaded, expected results
  logic [bs_pkg::CNT_W-1:0] count_reg = bs_pkg::COUNT_RESET;
  bs_pkg::word_t            set_store [DEPTH];
  int                       set_fill = 0;
  sorted_word_t             sorted_words [$];
  sorted_word_t             head;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int          fail_count = 0;
  int          cycle_count = 0;

  bitonic_sorter #(.DEPTH(DEPTH)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Give up after a generous cycle budget
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: stall at the configured rate, update only on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Result checker: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_words.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result word: sorted_value %0d last_value %b",
                   out_tdata, out_tlast);
      end else begin
        head = sorted_words.pop_front();
        if (out_tdata !== head.value || out_tlast !== head.last) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("result mismatch: expected %0d/%b, got %0d/%b",
                     head.value, head.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // Count in effect: zero acts as one, anything above the store depth saturates
  function automatic int active_count();
    int n;
    n = int'(count_reg);
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  // Bitonic network over the first n entries; the opening step of each stage
  // pairs mirror partners, later steps half-box partners; out-of-range
  // partners are skipped so any n ends up sorted.
  task automatic sort_loaded_set(input int n);
    int            levels;
    int            span;
    int            box;
    int            base;
    int            mate;
    bs_pkg::word_t held;
    levels = 0;
    while (levels < 7 && (1 << levels) < n) levels++;
    for (int stage = 1; stage <= levels; stage++) begin
      for (int step = 1; step <= stage; step++) begin
        span = stage - step + 1;
        box  = 1 << span;
        for (int i = 0; i < n; i++) begin
          base = (i >> span) << span;
          if (step == 1)
            mate = base + box - (i - base) - 1;
          else
            mate = (i - base < box / 2) ? i + box / 2 : i - box / 2;
          if (mate > i && mate < n && set_store[i] > set_store[mate]) begin
            held = set_store[i];
            set_store[i] = set_store[mate];
            set_store[mate] = held;
          end
        end
      end
    end
  endtask

  // Fold one accepted sample into the set; a completed set yields its sorted words
  task automatic load_sample(input bs_pkg::word_t value);
    int           n;
    sorted_word_t entry;
    n = active_count();
    if (set_fill >= n) set_fill = 0;
    set_store[set_fill] = value;
    set_fill++;
    if (set_fill == n) begin
      sort_loaded_set(n);
      for (int i = 0; i < n; i++) begin
        entry.value = set_store[i];
        entry.last  = (i == n - 1);
        sorted_words.push_back(entry);
      end
      set_fill = 0;
    end
  endtask

  // Send one word; called and returning at a falling edge. Valid stays high
  // on return so back-to-back words stream without a bubble.
  task automatic send_sample(input bs_pkg::word_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    load_sample(value);
    @(negedge clk);
  endtask

  // Mix of extremes, near-zero values that collide, and full-range noise
  function automatic bs_pkg::word_t draw_sample();
    case ($urandom_range(3))
      0: return bs_pkg::word_t'(int'($urandom_range(6)) - 3);
      1: return $urandom_range(1) ? bs_pkg::word_t'(32'h8000_0000) :
                                    bs_pkg::word_t'(32'h7FFF_FFFF);
      default: return bs_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_sample(draw_sample());
  endtask

  // Drop valid, wait for every expected word, then hold quiet for the settle period
  task automatic wait_drained(input int settle);
    in_tvalid <= 1'b0;
    while (sorted_words.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Register write: setup phase, then access phase until pready; discards the partial set
  task automatic write_count(input logic [bs_pkg::CNT_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= COUNT_ADDR;
    cfg_pwdata  <= bs_pkg::PDATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    count_reg = value;
    set_fill  = 0;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Reset count of 64 reads back before any write
  task automatic test_reset_count();
    logic [bs_pkg::PDATA_W-1:0] read_word;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= COUNT_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    read_word = cfg_prdata;
    if (read_word !== bs_pkg::PDATA_W'(bs_pkg::COUNT_RESET)) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("count readback mismatch: expected %0d, got %0d",
                 bs_pkg::COUNT_RESET, read_word);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Field extremes, duplicates, odd sizes, count of one and count of zero
  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_count(7'd8);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'sd5);
    send_sample(32'sd5);
    send_sample(32'h8000_0000);
    wait_drained(SETTLE_CYCLES);
    write_count(7'd3);
    send_sample(32'sd7);
    send_sample(-32'sd7);
    send_sample(32'sd0);
    wait_drained(SETTLE_CYCLES);
    write_count(7'd5);
    for (int v = 5; v >= 1; v--) send_sample(bs_pkg::word_t'(v));
    wait_drained(SETTLE_CYCLES);
    write_count(7'd1);
    send_sample(32'sd42);
    wait_drained(SETTLE_CYCLES);
    write_count(7'd0);
    send_sample(-32'sd5);
    wait_drained(SETTLE_CYCLES);
  endtask

  // A write partway through a set throws away the words loaded so far
  task automatic test_midset_write();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_count(7'd8);
    send_random(5);
    wait_drained(SETTLE_CYCLES);
    write_count(7'd4);
    send_random(4);
    wait_drained(SETTLE_CYCLES);
  endtask

  // Largest register value saturates to the store depth; two is the smallest network
  task automatic test_count_extremes();
    tx_idle_pct  = 24;
    rx_stall_pct = 24;
    write_count(7'd127);
    send_random(DEPTH);
    wait_drained(SETTLE_CYCLES);
    write_count(7'd2);
    send_random(2);
    send_random(2);
    wait_drained(SETTLE_CYCLES);
  endtask

  // Random sets across the idle phases; sets stream back to back unless the
  // count changes, and now and then a set is abandoned by a rewrite
  task automatic test_random_sets();
    int                       phase_words;
    int                       n;
    int                       pick;
    logic [bs_pkg::CNT_W-1:0] next_count;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      phase_words = 0;
      while (phase_words < 8) begin
        if (phase_words == 0 || $urandom_range(1) == 0) begin
          pick = $urandom_range(15);
          if (pick == 0)
            next_count = '0;
          else if (pick == 1)
            next_count = bs_pkg::CNT_W'($urandom_range(17, 40));
          else
            next_count = bs_pkg::CNT_W'($urandom_range(1, 16));
          wait_drained(SETTLE_CYCLES);
          write_count(next_count);
        end
        n = active_count();
        if (n > 1 && $urandom_range(7) == 0) begin
          send_random($urandom_range(1, n - 1));
          wait_drained(SETTLE_CYCLES);
          write_count(count_reg);
        end else begin
          send_random(n);
          phase_words += n;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_count();
    test_directed();
    test_midset_write();
    test_count_extremes();
    test_random_sets();
    wait_drained(END_CYCLES);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> bitonic_sorter.f
hw/rtl/bs_pkg.sv
hw/rtl/bs_store.sv
hw/rtl/bs_mate.sv
hw/rtl/bitonic_sorter.sv
tb/testbench.sv
